// ===== sv/vmc_pkg.sv =====
// Shared types, constants and helpers for the vending machine controller.
// Used by vmc_slot_table and vending_machine_controller_unit; depends on nothing.
package vmc_pkg;

  localparam int unsigned SLOTS_DEF = 16;
  localparam int unsigned SLOT_W    = 4;
  localparam int unsigned PRICE_W   = 8;
  localparam int unsigned QTY_W     = 8;
  localparam int unsigned BAL_W     = 16;
  localparam int unsigned CNT_W     = 9;   // holds any slot count up to 256
  localparam int unsigned IN_W      = 32;
  localparam int unsigned OUT_W     = 64;
  localparam int unsigned OUT_PAD_W = 6;

  typedef enum logic [2:0] {
    CMD_COIN    = 3'd0,
    CMD_SELECT  = 3'd1,
    CMD_RESTOCK = 3'd2,
    CMD_OPEN    = 3'd3,
    CMD_CLOSE   = 3'd4,
    CMD_CANCEL  = 3'd5
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_NOT_ALLOWED = 3'd1,
    ST_UNKNOWN     = 3'd2,
    ST_EMPTY       = 3'd3,
    ST_LOW_BALANCE = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    MODE_NO_COIN  = 4'b0001,
    MODE_HAS_COIN = 4'b0010,
    MODE_OOS      = 4'b0100,
    MODE_MAINT    = 4'b1000
  } mode_e;

  localparam logic [1:0] MODE_CODE_NO_COIN  = 2'd0;
  localparam logic [1:0] MODE_CODE_HAS_COIN = 2'd1;
  localparam logic [1:0] MODE_CODE_OOS      = 2'd2;
  localparam logic [1:0] MODE_CODE_MAINT    = 2'd3;

  typedef struct packed {
    logic               valid;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
  } slot_entry_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] idx;
    slot_entry_t       entry;
  } slot_wr_t;

  function automatic logic [3:0] coin_value(input logic [1:0] code);
    logic [3:0] v;
    unique case (code)
      2'd0:    v = 4'd1;
      2'd1:    v = 4'd2;
      2'd2:    v = 4'd5;
      default: v = 4'd10;
    endcase
    return v;
  endfunction

  function automatic logic [1:0] mode_code(input mode_e m);
    logic [1:0] c;
    unique case (m)
      MODE_NO_COIN:  c = MODE_CODE_NO_COIN;
      MODE_HAS_COIN: c = MODE_CODE_HAS_COIN;
      MODE_OOS:      c = MODE_CODE_OOS;
      MODE_MAINT:    c = MODE_CODE_MAINT;
      default:       c = MODE_CODE_OOS;
    endcase
    return c;
  endfunction

endpackage

// ===== sv/vmc_slot_table.sv =====
// Slot table: valid flag, price and quantity per slot, one read and one write port.
// Also reports whether any slot other than the one read still holds stock. Uses vmc_pkg.
module vmc_slot_table #(
  parameter int unsigned SLOTS = vmc_pkg::SLOTS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [vmc_pkg::SLOT_W-1:0]          rd_idx_i,
  output vmc_pkg::slot_entry_t                rd_entry_o,
  output logic                                others_stock_o,
  input  vmc_pkg::slot_wr_t                   wr_i
);
  import vmc_pkg::*;

  // only the slots that the index field can reach get storage
  localparam int unsigned DEPTH = (SLOTS < (1 << SLOT_W)) ? SLOTS : (1 << SLOT_W);
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  slot_entry_t entry_q [DEPTH];

  logic             rd_hit;
  logic             wr_hit;
  logic [IDX_W-1:0] rd_idx;
  logic [IDX_W-1:0] wr_idx;

  assign rd_hit = (CNT_W'(rd_idx_i) < CNT_W'(DEPTH));
  assign wr_hit = (CNT_W'(wr_i.idx) < CNT_W'(DEPTH));
  assign rd_idx = rd_idx_i[IDX_W-1:0];
  assign wr_idx = wr_i.idx[IDX_W-1:0];

  // unreachable slots read as a never-restocked entry
  assign rd_entry_o = rd_hit ? entry_q[rd_idx] : '0;

  always_comb begin
    others_stock_o = 1'b0;
    for (int unsigned i = 0; i < DEPTH; i++) begin
      if (!rd_hit || (IDX_W'(i) != rd_idx)) begin
        others_stock_o = others_stock_o | (entry_q[i].qty != '0);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned i = 0; i < DEPTH; i++) begin
        entry_q[i] <= '0;
      end
    end else if (wr_i.en && wr_hit) begin
      entry_q[wr_idx] <= wr_i.entry;
    end
  end

endmodule

// ===== sv/vending_machine_controller_unit.sv =====
// Vending machine controller top level: input register, command decode and result register.
// Uses vmc_pkg and vmc_slot_table.
//
// Usage: each request on the s_axis channel carries one command (insert coin, select,
// restock, open panel, close panel, cancel) with its coin code, slot, price and
// quantity. Exactly one result leaves on the m_axis channel for every request, in
// order, carrying status, mode after the step, balance, vend flag and slot, change
// and refund.
// A request accepted into the input register is decoded from it, and its result is loaded
// into the result register, from which the receiver takes it. Throughput is one request
// per cycle while the receiver does not stall; the slot table is read and written in the same
// cycle that the command is decoded, so the next request sees the updated table.
// Reset clears the slot table, empties the balance and puts the machine out of stock;
// both channels come up empty.
// When the receiver stalls the result register holds its value, the pending request
// waits in the input register, and s_axis_tready drops once both are full.
module vending_machine_controller_unit #(
  parameter int unsigned SLOTS = vmc_pkg::SLOTS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // command[2:0], coin_code[4:3], slot[8:5], restock_price[16:9],
  // restock_quantity[24:17], zero fill [31:25]
  input  logic [vmc_pkg::IN_W-1:0]  s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // status[2:0], mode_after[4:3], balance_now[20:5], vended[21], vended_slot[25:22],
  // change_due[41:26], refund_due[57:42], zero fill [63:58]
  output logic [vmc_pkg::OUT_W-1:0] m_axis_tdata
);
  import vmc_pkg::*;

  // input register
  logic               in_valid_q, in_valid_d;
  logic [2:0]         cmd_q;
  logic [1:0]         coin_q;
  logic [SLOT_W-1:0]  slot_q;
  logic [PRICE_W-1:0] rprice_q;
  logic [QTY_W-1:0]   rqty_q;

  // machine state
  mode_e            mode_q, mode_d;
  logic [BAL_W-1:0] bal_q, bal_d;

  // result register
  logic             out_valid_q, out_valid_d;
  logic [OUT_W-1:0] out_data_q, out_data_d;

  logic s_accept;
  logic advance;

  slot_entry_t rd_entry;
  logic        others_stock;
  slot_wr_t    wr, wr_gated;

  logic               in_range;
  logic [BAL_W:0]     bal_sum;
  logic [QTY_W:0]     qty_sum;
  logic [QTY_W-1:0]   qty_dec;
  status_e            status;
  logic               vended;
  logic [SLOT_W-1:0]  vslot;
  logic [BAL_W-1:0]   change;
  logic [BAL_W-1:0]   refund;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  vmc_slot_table #(
    .SLOTS (SLOTS)
  ) u_slot_table (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .rd_idx_i       (slot_q),
    .rd_entry_o     (rd_entry),
    .others_stock_o (others_stock),
    .wr_i           (wr_gated)
  );

  assign in_range = (CNT_W'(slot_q) < CNT_W'(SLOTS));
  assign bal_sum  = {1'b0, bal_q} + (BAL_W + 1)'(coin_value(coin_q));
  assign qty_sum  = {1'b0, rd_entry.qty} + {1'b0, rqty_q};
  assign qty_dec  = rd_entry.qty - QTY_W'(1);

  always_comb begin
    mode_d = mode_q;
    bal_d  = bal_q;
    wr     = '0;
    status = ST_NOT_ALLOWED;
    vended = 1'b0;
    vslot  = '0;
    change = '0;
    refund = '0;
    unique case (cmd_q)
      CMD_COIN: begin
        if (mode_q == MODE_NO_COIN || mode_q == MODE_HAS_COIN) begin
          bal_d  = bal_sum[BAL_W] ? '1 : bal_sum[BAL_W-1:0];
          mode_d = MODE_HAS_COIN;
          status = ST_OK;
        end
      end
      CMD_SELECT: begin
        if (mode_q == MODE_HAS_COIN) begin
          priority if (!in_range || !rd_entry.valid) begin
            status = ST_UNKNOWN;
          end else if (rd_entry.qty == '0) begin
            status = ST_EMPTY;
          end else if (bal_q < BAL_W'(rd_entry.price)) begin
            status = ST_LOW_BALANCE;
          end else begin
            wr.en        = 1'b1;
            wr.idx       = slot_q;
            wr.entry     = rd_entry;
            wr.entry.qty = qty_dec;
            change       = bal_q - BAL_W'(rd_entry.price);
            bal_d        = '0;
            vended       = 1'b1;
            vslot        = slot_q;
            // out of stock once the last unit anywhere has gone
            mode_d       = (others_stock || (qty_dec != '0)) ? MODE_NO_COIN : MODE_OOS;
            status       = ST_OK;
          end
        end
      end
      CMD_RESTOCK: begin
        if (mode_q == MODE_MAINT) begin
          if (!in_range) begin
            status = ST_UNKNOWN;
          end else begin
            wr.en          = 1'b1;
            wr.idx         = slot_q;
            wr.entry.valid = 1'b1;
            if (!rd_entry.valid) begin
              wr.entry.price = rprice_q;
              wr.entry.qty   = rqty_q;
            end else begin
              wr.entry.price = rd_entry.price;
              wr.entry.qty   = qty_sum[QTY_W] ? '1 : qty_sum[QTY_W-1:0];
            end
            status = ST_OK;
          end
        end
      end
      CMD_OPEN: begin
        if (mode_q == MODE_NO_COIN || mode_q == MODE_OOS) begin
          mode_d = MODE_MAINT;
          status = ST_OK;
        end
      end
      CMD_CLOSE: begin
        if (mode_q == MODE_MAINT) begin
          mode_d = (others_stock || (rd_entry.qty != '0)) ? MODE_NO_COIN : MODE_OOS;
          status = ST_OK;
        end
      end
      CMD_CANCEL: begin
        if (mode_q == MODE_HAS_COIN) begin
          refund = bal_q;
          bal_d  = '0;
          mode_d = MODE_NO_COIN;
          status = ST_OK;
        end
      end
      default: begin
        status = ST_NOT_ALLOWED;
      end
    endcase
  end

  always_comb begin
    wr_gated    = wr;
    wr_gated.en = wr.en && advance;
  end

  assign in_valid_d  = s_accept ? 1'b1 : (advance ? 1'b0 : in_valid_q);
  assign out_valid_d = advance ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);
  assign out_data_d  = {{OUT_PAD_W{1'b0}}, refund, change, vslot, vended, bal_d,
                        mode_code(mode_d), status};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      mode_q      <= MODE_OOS;
      bal_q       <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        mode_q <= mode_d;
        bal_q  <= bal_d;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      cmd_q    <= s_axis_tdata[2:0];
      coin_q   <= s_axis_tdata[4:3];
      slot_q   <= s_axis_tdata[8:5];
      rprice_q <= s_axis_tdata[16:9];
      rqty_q   <= s_axis_tdata[24:17];
    end
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

  // a dispense always reports success and leaves no balance behind
  a_vend_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[21]) |->
      (m_axis_tdata[2:0] == ST_OK && m_axis_tdata[20:5] == '0))
    else $error("dispense without success or with balance left");

  // a refund only happens on cancel, which always lands in no coin
  a_refund_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[57:42] != '0) |->
      (m_axis_tdata[4:3] == MODE_CODE_NO_COIN && !m_axis_tdata[21]))
    else $error("refund outside cancel");

  // back-pressure only when both the input and result registers are occupied
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid_q && out_valid_q && !m_axis_tready))
    else $error("input stalled with room to advance");

  // state moves only when a request is processed
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> ($stable(mode_q) && $stable(bal_q)))
    else $error("state changed without a request");

  // a processed request always produces a result on the next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> m_axis_tvalid)
    else $error("processed request left no result");

endmodule

// ===== test/vending_machine_controller_unit_tb.sv =====
// Self-checking testbench for vending_machine_controller_unit: directed mode and slot cases,
// a long full-rate stretch, output back-pressure and random customer/maintenance sessions.
// Depends on vmc_pkg and the controller RTL only.
module vending_machine_controller_unit_tb;
  import vmc_pkg::*;

  localparam int unsigned NSLOT       = SLOTS_DEF;
  localparam logic [2:0]  CMD_SPARE_6 = 3'd6;
  localparam logic [2:0]  CMD_SPARE_7 = 3'd7;
  localparam int          RANDOM_REQS = 1300;
  localparam int          FULL_RATE_N = 300;
  localparam int          MAX_REPORTS = 10;
  localparam int          DRAIN_LIMIT = 2000;
  localparam int          HOLD_CYCLES = 300;

  typedef struct packed {
    logic [6:0]  fill;
    logic [7:0]  qty;
    logic [7:0]  price;
    logic [3:0]  slot;
    logic [1:0]  coin;
    logic [2:0]  cmd;
  } vend_request_t;

  typedef struct packed {
    logic [5:0]  fill;
    logic [15:0] refund_due;
    logic [15:0] change_due;
    logic [3:0]  vended_slot;
    logic        vended;
    logic [15:0] balance_now;
    logic [1:0]  mode_after;
    logic [2:0]  status;
  } vend_result_t;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // command[2:0], coin_code[4:3], slot[8:5], restock_price[16:9],
  // restock_quantity[24:17], zero fill [31:25]
  logic [31:0] s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // status[2:0], mode_after[4:3], balance_now[20:5], vended[21], vended_slot[25:22],
  // change_due[41:26], refund_due[57:42], zero fill [63:58]
  logic [63:0] m_axis_tdata;

  // Shadow of the machine state
  logic [1:0]  cur_mode;
  logic [15:0] cur_balance;
  logic        slot_known [NSLOT];
  logic [7:0]  slot_cost  [NSLOT];
  logic [7:0]  slot_stock [NSLOT];

  vend_result_t expected_results [$];

  int  mismatches      = 0;
  int  requests_sent   = 0;
  int  results_checked = 0;
  int  dispenses       = 0;
  int  refunds         = 0;
  bit  tx_gaps_on      = 1'b1;
  bit  rx_gaps_on      = 1'b1;
  int  hold_req        = 0;
  int  hold_left       = 0;

  vending_machine_controller_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("FAIL vending_machine_controller_unit");
    $finish;
  end

  function automatic logic [3:0] coin_units(input logic [1:0] code);
    case (code)
      2'd0:    return 4'd1;
      2'd1:    return 4'd2;
      2'd2:    return 4'd5;
      default: return 4'd10;
    endcase
  endfunction

  function automatic logic [1:0] resting_mode();
    for (int i = 0; i < NSLOT; i++) begin
      if (slot_stock[i] != 8'd0) return MODE_CODE_NO_COIN;
    end
    return MODE_CODE_OOS;
  endfunction

  function automatic void clear_machine();
    cur_mode    = MODE_CODE_OOS;
    cur_balance = '0;
    for (int i = 0; i < NSLOT; i++) begin
      slot_known[i] = 1'b0;
      slot_cost[i]  = '0;
      slot_stock[i] = '0;
    end
  endfunction

  // Apply one request to the shadow state and return the result it should produce
  function automatic vend_result_t vend_step(input vend_request_t rq);
    vend_result_t r;
    logic [16:0]  sum;
    logic [8:0]   stock_sum;
    r        = '0;
    r.status = ST_NOT_ALLOWED;
    case (rq.cmd)
      CMD_COIN: begin
        if (cur_mode == MODE_CODE_NO_COIN || cur_mode == MODE_CODE_HAS_COIN) begin
          sum         = {1'b0, cur_balance} + 17'(coin_units(rq.coin));
          cur_balance = sum[16] ? 16'hFFFF : sum[15:0];
          cur_mode    = MODE_CODE_HAS_COIN;
          r.status    = ST_OK;
        end
      end
      CMD_SELECT: begin
        if (cur_mode == MODE_CODE_HAS_COIN) begin
          if (rq.slot >= NSLOT || !slot_known[rq.slot]) begin
            r.status = ST_UNKNOWN;
          end else if (slot_stock[rq.slot] == 8'd0) begin
            r.status = ST_EMPTY;
          end else if (cur_balance < 16'(slot_cost[rq.slot])) begin
            r.status = ST_LOW_BALANCE;
          end else begin
            slot_stock[rq.slot] = slot_stock[rq.slot] - 8'd1;
            r.change_due  = cur_balance - 16'(slot_cost[rq.slot]);
            cur_balance   = '0;
            r.vended      = 1'b1;
            r.vended_slot = rq.slot;
            cur_mode      = resting_mode();
            r.status      = ST_OK;
          end
        end
      end
      CMD_RESTOCK: begin
        if (cur_mode == MODE_CODE_MAINT) begin
          if (rq.slot >= NSLOT) begin
            r.status = ST_UNKNOWN;
          end else begin
            if (!slot_known[rq.slot]) begin
              slot_known[rq.slot] = 1'b1;
              slot_cost[rq.slot]  = rq.price;
              slot_stock[rq.slot] = rq.qty;
            end else begin
              stock_sum = {1'b0, slot_stock[rq.slot]} + {1'b0, rq.qty};
              slot_stock[rq.slot] = stock_sum[8] ? 8'hFF : stock_sum[7:0];
            end
            r.status = ST_OK;
          end
        end
      end
      CMD_OPEN: begin
        if (cur_mode == MODE_CODE_NO_COIN || cur_mode == MODE_CODE_OOS) begin
          cur_mode = MODE_CODE_MAINT;
          r.status = ST_OK;
        end
      end
      CMD_CLOSE: begin
        if (cur_mode == MODE_CODE_MAINT) begin
          cur_mode = resting_mode();
          r.status = ST_OK;
        end
      end
      CMD_CANCEL: begin
        if (cur_mode == MODE_CODE_HAS_COIN) begin
          r.refund_due = cur_balance;
          cur_balance  = '0;
          cur_mode     = MODE_CODE_NO_COIN;
          r.status     = ST_OK;
        end
      end
      default: ;
    endcase
    r.mode_after  = cur_mode;
    r.balance_now = cur_balance;
    return r;
  endfunction

  // Offer one request, hold it until accepted, then record its expected result
  task automatic send_request(input logic [2:0] cmd, input logic [1:0] coin,
                              input logic [3:0] slot, input logic [7:0] price,
                              input logic [7:0] qty);
    vend_request_t rq;
    rq = {7'd0, qty, price, slot, coin, cmd};
    while (tx_gaps_on && $urandom_range(99) < 8) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= rq;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_results.insert(expected_results.size(), vend_step(rq));
    requests_sent++;
  endtask

  task automatic send_any(input logic [2:0] cmd);
    send_request(cmd, 2'($urandom_range(3)), 4'($urandom_range(15)),
                 8'($urandom_range(255)), 8'($urandom_range(255)));
  endtask

  function automatic logic [7:0] pick_price();
    if ($urandom_range(1) == 0) return 8'($urandom_range(30));
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [7:0] pick_qty();
    int r;
    r = $urandom_range(19);
    if (r == 0) return 8'($urandom_range(255));
    if (r < 3) return 8'd0;
    return 8'($urandom_range(1, 3));
  endfunction

  // Result receiver: random stalls, or a counted hold-off when asked
  always @(posedge clk_i) begin : rx_side
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req <= 0;
    end
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left--;
    end else if (rx_gaps_on) begin
      m_axis_tready <= ($urandom_range(99) >= 8);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : result_check
    vend_result_t got;
    vend_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (got.vended) dispenses++;
      if (got.refund_due != 16'd0) refunds++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result %h with nothing outstanding", got);
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display({"mismatch %0d (exp/got): status %0d/%0d mode %0d/%0d ",
                      "balance %0d/%0d vended %0d/%0d slot %0d/%0d change %0d/%0d ",
                      "refund %0d/%0d fill %0h/%0h"},
                     mismatches, want.status, got.status, want.mode_after, got.mode_after,
                     want.balance_now, got.balance_now, want.vended, got.vended,
                     want.vended_slot, got.vended_slot, want.change_due, got.change_due,
                     want.refund_due, got.refund_due, want.fill, got.fill);
        end
      end
    end
  end

  // Out of stock after reset: only open panel is allowed, then maintenance refusals
  task automatic test_idle_modes();
    send_any(CMD_COIN);
    send_any(CMD_SELECT);
    send_any(CMD_RESTOCK);
    send_any(CMD_CLOSE);
    send_any(CMD_CANCEL);
    send_any(CMD_SPARE_6);
    send_any(CMD_SPARE_7);
    send_any(CMD_OPEN);
    send_any(CMD_OPEN);
    send_any(CMD_COIN);
    send_any(CMD_SELECT);
    send_any(CMD_CANCEL);
  endtask

  task automatic test_restock();
    send_request(CMD_RESTOCK, 2'd0, 4'd3, 8'd7, 8'd1);
    // known slot with nothing in it
    send_request(CMD_RESTOCK, 2'd3, 4'd0, 8'd0, 8'd0);
    send_request(CMD_CLOSE, 2'd0, 4'd0, 8'd0, 8'd0);
  endtask

  // Last unit sold leaves the machine out of stock
  task automatic test_sell_out();
    send_request(CMD_COIN, 2'd3, 4'd0, 8'd0, 8'd0);
    send_request(CMD_SELECT, 2'd0, 4'd0, 8'd0, 8'd0);
    send_request(CMD_SELECT, 2'd0, 4'd9, 8'd0, 8'd0);
    send_request(CMD_OPEN, 2'd0, 4'd0, 8'd0, 8'd0);
    send_request(CMD_SELECT, 2'd0, 4'd3, 8'd0, 8'd0);
  endtask

  task automatic test_purchase();
    send_request(CMD_OPEN, 2'd0, 4'd0, 8'd0, 8'd0);
    // price must stay at its first value
    send_request(CMD_RESTOCK, 2'd0, 4'd3, 8'd99, 8'd2);
    send_request(CMD_RESTOCK, 2'd0, 4'd15, 8'd255, 8'd255);
    send_request(CMD_RESTOCK, 2'd0, 4'd15, 8'd0, 8'd1);
    send_request(CMD_CLOSE, 2'd0, 4'd0, 8'd0, 8'd0);
    send_request(CMD_CANCEL, 2'd0, 4'd0, 8'd0, 8'd0);
    send_request(CMD_COIN, 2'd0, 4'd0, 8'd0, 8'd0);
    send_request(CMD_COIN, 2'd1, 4'd0, 8'd0, 8'd0);
    send_request(CMD_COIN, 2'd2, 4'd0, 8'd0, 8'd0);
    send_request(CMD_SELECT, 2'd0, 4'd15, 8'd0, 8'd0);
    send_request(CMD_CANCEL, 2'd0, 4'd0, 8'd0, 8'd0);
    send_request(CMD_COIN, 2'd3, 4'd0, 8'd0, 8'd0);
    send_request(CMD_SELECT, 2'd0, 4'd3, 8'd0, 8'd0);
  endtask

  // Build a large balance at full rate on both sides, then spend it on the dearest slot
  task automatic test_full_rate();
    tx_gaps_on = 1'b0;
    rx_gaps_on <= 1'b0;
    repeat (FULL_RATE_N) send_request(CMD_COIN, 2'd3, 4'($urandom_range(15)),
                                      8'($urandom_range(255)), 8'($urandom_range(255)));
    send_request(CMD_COIN, 2'd0, 4'd0, 8'd0, 8'd0);
    send_request(CMD_SELECT, 2'd0, 4'd15, 8'd0, 8'd0);
    tx_gaps_on = 1'b1;
    rx_gaps_on <= 1'b1;
  endtask

  // Receiver holds off while requests keep coming, so the input side must stall
  task automatic test_backpressure();
    hold_req <= HOLD_CYCLES;
    repeat (40) begin
      if ($urandom_range(1) == 0) send_any(CMD_COIN);
      else send_any(CMD_SELECT);
    end
  endtask

  task automatic test_random_traffic();
    int kind;
    int n;
    int stop_at;
    stop_at = requests_sent + RANDOM_REQS;
    while (requests_sent < stop_at) begin
      kind = $urandom_range(99);
      if (kind < 25) begin
        send_any(CMD_OPEN);
        n = $urandom_range(1, 4);
        repeat (n) send_request(CMD_RESTOCK, 2'($urandom_range(3)), 4'($urandom_range(15)),
                                pick_price(), pick_qty());
        send_any(CMD_CLOSE);
      end else if (kind < 75) begin
        n = ($urandom_range(9) == 0) ? 30 : $urandom_range(1, 8);
        repeat (n) send_any(CMD_COIN);
        send_any(CMD_SELECT);
        if ($urandom_range(3) == 0) send_any(CMD_SELECT);
        if ($urandom_range(4) == 0) send_any(CMD_CANCEL);
      end else if (kind < 90) begin
        n = $urandom_range(1, 5);
        repeat (n) send_any(CMD_COIN);
        send_any(CMD_CANCEL);
      end else begin
        n = $urandom_range(1, 3);
        repeat (n) send_any(3'($urandom_range(7)));
      end
    end
  endtask

  initial begin : main
    int waited;
    clear_machine();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_idle_modes();
    test_restock();
    test_sell_out();
    test_purchase();
    test_full_rate();
    test_backpressure();
    test_random_traffic();
    s_axis_tvalid <= 1'b0;
    waited = 0;
    while (expected_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (8) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      $display("%0d results never arrived", expected_results.size());
      mismatches += expected_results.size();
    end
    $display("covered %0d requests, %0d results checked, %0d dispenses, %0d refunds",
             requests_sent, results_checked, dispenses, refunds);
    $display("mode refusals, restock rules, sell-out, full-rate stretch, output hold-off");
    if (mismatches == 0) begin
      $display("PASS vending_machine_controller_unit");
    end else begin
      $display("FAIL vending_machine_controller_unit");
    end
    $finish;
  end

endmodule
